// ===== hw/rtl/fcfs_schedule_metrics_unit_defines.svh =====
// Assertion macros used by the scheduler back end.
// Depends on nothing; the files that use the macros must have clk and rst_n in scope.
`ifndef FCFS_SCHEDULE_METRICS_UNIT_DEFINES_SVH
`define FCFS_SCHEDULE_METRICS_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define FCFS_SM_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Next-cycle implication, disabled during reset.
`define FCFS_SM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

// ===== hw/rtl/fcfs_sm_pkg.sv =====
// Shared types and constants of the FCFS schedule metrics unit.
// Depends on nothing; the front, queue, back and top files refer to it by scoped names.
package fcfs_sm_pkg;

    localparam int unsigned QUEUE_DEPTH = 2;

    typedef struct packed {
        logic [15:0] arrival_time;
        logic [15:0] burst_time;
        logic        last_item;
    } proc_item_t;

    typedef struct packed {
        logic [4:0]  process_number;
        logic [15:0] arrival_out;
        logic [15:0] burst_out;
        logic [20:0] completion_time;
        logic [19:0] turnaround_time;
        logic [19:0] waiting_time;
        logic [19:0] average_turnaround;
        logic [19:0] average_waiting;
        logic        dropped;
        logic        last_result;
    } result_item_t;

    // Classified record passed from front to back.
    typedef struct packed {
        logic [15:0] arrival;
        logic [15:0] burst;
        logic        keep;
        logic        last;
        logic        ovf;
    } q_rec_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef enum logic [3:0] {
        ST_LOAD,
        ST_SUM,
        ST_FIN,
        ST_TSUM,
        ST_WSUM,
        ST_DSTART,
        ST_DIV,
        ST_CALC,
        ST_EMIT
    } back_state_t;

endpackage

// ===== hw/rtl/fcfs_sm_chan_if.sv =====
// Valid/ready channel interface carrying one payload struct.
// Depends on fcfs_sm_pkg for the payload types used by its instances.
interface fcfs_sm_chan_if #(parameter type T = logic);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ===== hw/rtl/fcfs_sm_front.sv =====
// Front end: takes process items, counts them, drops overflow, feeds the queue.
// Depends on fcfs_sm_pkg and fcfs_sm_chan_if.
module fcfs_sm_front #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    fcfs_sm_chan_if.sink         proc,
    input  fcfs_sm_pkg::q_stat_t q_stat,
    output logic                 push,
    output fcfs_sm_pkg::q_rec_t  rec
);
    localparam int unsigned NW = $clog2(MAX_PROCS + 1);

    logic [NW-1:0] count_reg, count_next;
    logic          ovf_reg, ovf_next;
    logic          xfer;
    logic          room;

    assign proc.ready = !q_stat.full;
    assign xfer       = proc.valid && proc.ready;
    assign room       = count_reg < NW'(MAX_PROCS);
    assign push       = xfer && (room || proc.data.last_item);

    assign rec.arrival = proc.data.arrival_time;
    assign rec.burst   = proc.data.burst_time;
    assign rec.keep    = room;
    assign rec.last    = proc.data.last_item;
    assign rec.ovf     = ovf_reg || !room;

    always_comb
    begin
        count_next = count_reg;
        ovf_next   = ovf_reg;
        if (xfer)
        begin
            if (proc.data.last_item)
            begin
                count_next = '0;
                ovf_next   = 1'b0;
            end
            else if (room)
            begin
                count_next = count_reg + NW'(1);
            end
            else
            begin
                ovf_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            ovf_reg   <= ovf_next;
        end
    end
endmodule

// ===== hw/rtl/fcfs_sm_queue.sv =====
// Short FIFO between front and back so each side stalls on its own.
// Depends on fcfs_sm_pkg for depth and status types.
module fcfs_sm_queue (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 push,
    input  fcfs_sm_pkg::q_rec_t  wr_data,
    input  logic                 pop,
    output fcfs_sm_pkg::q_rec_t  rd_data,
    output fcfs_sm_pkg::q_stat_t stat
);
    localparam int unsigned QW = $clog2(fcfs_sm_pkg::QUEUE_DEPTH);

    fcfs_sm_pkg::q_rec_t mem_reg [fcfs_sm_pkg::QUEUE_DEPTH];
    logic [QW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QW:0]   fill_reg, fill_next;
    logic          do_push, do_pop;

    assign stat.full  = fill_reg == (QW+1)'(fcfs_sm_pkg::QUEUE_DEPTH);
    assign stat.empty = fill_reg == '0;
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign rd_data    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + QW'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + QW'(1) : rd_ptr_reg;
        fill_next   = fill_reg;
        if (do_push && !do_pop)
        begin
            fill_next = fill_reg + (QW+1)'(1);
        end
        else if (do_pop && !do_push)
        begin
            fill_next = fill_reg - (QW+1)'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end
endmodule

// ===== hw/rtl/fcfs_sm_div.sv =====
// Restoring divider, one quotient bit per cycle.
// Depends on nothing but its parameters.
module fcfs_sm_div #(
    parameter int unsigned DW = 27,
    parameter int unsigned VW = 5
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    input  logic [DW-1:0] dividend,
    input  logic [VW-1:0] divisor,
    output logic          done,
    output logic [DW-1:0] quotient
);
    localparam int unsigned CNW = $clog2(DW + 1);

    logic [VW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  quo_reg, quo_next;
    logic [VW-1:0]  dvs_reg, dvs_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic [VW:0]    trial;
    logic           ge;

    assign trial    = {rem_reg, quo_reg[DW-1]};
    assign ge       = trial >= {1'b0, dvs_reg};
    assign done     = done_reg;
    assign quotient = quo_reg;

    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quo_next  = dividend;
            dvs_next  = divisor;
            cnt_next  = CNW'(DW);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next = ge ? VW'(trial - {1'b0, dvs_reg}) : VW'(trial);
            quo_next = {quo_reg[DW-2:0], ge};
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == CNW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        dvs_reg <= dvs_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end
endmodule

// ===== hw/rtl/fcfs_sm_back.sv =====
// Back end: sorted insertion row, schedule passes, averages and result register.
// Depends on fcfs_sm_pkg, fcfs_sm_chan_if, fcfs_sm_div and the defines header.
`include "fcfs_schedule_metrics_unit_defines.svh"

module fcfs_sm_back #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  fcfs_sm_pkg::q_stat_t q_stat,
    input  fcfs_sm_pkg::q_rec_t  head,
    output logic                 pop,
    fcfs_sm_chan_if.source       result
);
    localparam int unsigned NW  = $clog2(MAX_PROCS + 1);
    localparam int unsigned IW  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
    localparam int unsigned CW  = (16 + NW > 22) ? 16 + NW : 22;
    localparam int unsigned SW  = CW + NW;
    localparam int unsigned XW  = (IW + 1 > 5) ? IW + 1 : 5;

    fcfs_sm_pkg::back_state_t state_reg, state_next;

    // sorted row of processes, ascending arrival, stable
    logic [15:0]          cell_a_reg [MAX_PROCS];
    logic [15:0]          cell_b_reg [MAX_PROCS];
    logic [IW-1:0]        cell_i_reg [MAX_PROCS];
    logic [15:0]          cell_a_next [MAX_PROCS];
    logic [15:0]          cell_b_next [MAX_PROCS];
    logic [IW-1:0]        cell_i_next [MAX_PROCS];
    logic [MAX_PROCS-1:0] valid_reg, valid_next;
    logic [MAX_PROCS-1:0] ins;

    logic [NW-1:0] n_reg, n_next;
    logic [NW-1:0] cnt_reg, cnt_next;
    logic          ovf_reg, ovf_next;
    logic [CW-1:0] prev_reg, prev_next;
    logic [SW-1:0] sum_c_reg, sum_c_next;
    logic [SW-1:0] sum_a_reg, sum_a_next;
    logic [SW-1:0] sum_b_reg, sum_b_next;
    logic [19:0]   avg_t_reg, avg_t_next;
    logic [19:0]   avg_w_reg, avg_w_next;
    logic [15:0]   stg_a_reg, stg_a_next;
    logic [15:0]   stg_b_reg, stg_b_next;
    logic [IW-1:0] stg_i_reg, stg_i_next;
    logic          stg_last_reg, stg_last_next;

    logic                       out_valid_reg, out_valid_next;
    fcfs_sm_pkg::result_item_t  out_data_reg, out_data_next;

    logic          rotate;
    logic          insert;
    logic          clear;
    logic          div_start;
    logic          div_t_done;
    logic          div_w_done;
    logic [SW-1:0] quo_t;
    logic [SW-1:0] quo_w;
    logic [CW-1:0] head_a;
    logic [CW-1:0] start_t;
    logic [CW-1:0] comp;
    logic [CW-1:0] tat;
    logic [CW-1:0] wt;
    logic [XW-1:0] pnum;
    logic          out_free;

    assign pop      = (state_reg == fcfs_sm_pkg::ST_LOAD) && !q_stat.empty;
    assign insert   = pop && head.keep;
    assign out_free = !out_valid_reg || result.ready;

    assign result.valid = out_valid_reg;
    assign result.data  = out_data_reg;

    // one schedule step on the row head
    assign head_a  = CW'(cell_a_reg[0]);
    assign start_t = (prev_reg > head_a) ? prev_reg : head_a;
    assign comp    = start_t + CW'(cell_b_reg[0]);

    assign tat  = prev_reg - CW'(stg_a_reg);
    assign wt   = tat - CW'(stg_b_reg);
    assign pnum = XW'(stg_i_reg) + XW'(1);

    fcfs_sm_div #(.DW(SW), .VW(NW)) u_div_t (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_c_reg),
        .divisor  (n_reg),
        .done     (div_t_done),
        .quotient (quo_t)
    );

    fcfs_sm_div #(.DW(SW), .VW(NW)) u_div_w (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (sum_a_reg),
        .divisor  (n_reg),
        .done     (div_w_done),
        .quotient (quo_w)
    );

    // row update: insert, rotate or clear
    always_comb
    begin
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            ins[j] = !valid_reg[j] || (cell_a_reg[j] > head.arrival);
        end
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            cell_a_next[j] = cell_a_reg[j];
            cell_b_next[j] = cell_b_reg[j];
            cell_i_next[j] = cell_i_reg[j];
            valid_next[j]  = valid_reg[j];
            if (clear)
            begin
                valid_next[j] = 1'b0;
            end
            else if (insert)
            begin
                if (ins[j])
                begin
                    if (j > 0 && ins[(j > 0) ? j - 1 : 0])
                    begin
                        cell_a_next[j] = cell_a_reg[(j > 0) ? j - 1 : 0];
                        cell_b_next[j] = cell_b_reg[(j > 0) ? j - 1 : 0];
                        cell_i_next[j] = cell_i_reg[(j > 0) ? j - 1 : 0];
                    end
                    else
                    begin
                        cell_a_next[j] = head.arrival;
                        cell_b_next[j] = head.burst;
                        cell_i_next[j] = IW'(n_reg);
                    end
                end
                valid_next[j] = valid_reg[j] || (j == 0) || valid_reg[(j > 0) ? j - 1 : 0];
            end
            else if (rotate)
            begin
                if (NW'(j + 1) < n_reg)
                begin
                    cell_a_next[j] = cell_a_reg[(j < MAX_PROCS - 1) ? j + 1 : j];
                    cell_b_next[j] = cell_b_reg[(j < MAX_PROCS - 1) ? j + 1 : j];
                    cell_i_next[j] = cell_i_reg[(j < MAX_PROCS - 1) ? j + 1 : j];
                end
                else if (NW'(j + 1) == n_reg)
                begin
                    cell_a_next[j] = cell_a_reg[0];
                    cell_b_next[j] = cell_b_reg[0];
                    cell_i_next[j] = cell_i_reg[0];
                end
            end
        end
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        n_next         = n_reg;
        cnt_next       = cnt_reg;
        ovf_next       = ovf_reg;
        prev_next      = prev_reg;
        sum_c_next     = sum_c_reg;
        sum_a_next     = sum_a_reg;
        sum_b_next     = sum_b_reg;
        avg_t_next     = avg_t_reg;
        avg_w_next     = avg_w_reg;
        stg_a_next     = stg_a_reg;
        stg_b_next     = stg_b_reg;
        stg_i_next     = stg_i_reg;
        stg_last_next  = stg_last_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        rotate         = 1'b0;
        clear          = 1'b0;
        div_start      = 1'b0;

        if (out_valid_reg && result.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            fcfs_sm_pkg::ST_LOAD:
            begin
                if (pop)
                begin
                    if (head.keep)
                    begin
                        n_next = n_reg + NW'(1);
                    end
                    if (head.last)
                    begin
                        ovf_next   = head.ovf;
                        cnt_next   = '0;
                        prev_next  = '0;
                        sum_c_next = '0;
                        sum_a_next = '0;
                        sum_b_next = '0;
                        state_next = fcfs_sm_pkg::ST_SUM;
                    end
                end
            end
            fcfs_sm_pkg::ST_SUM:
            begin
                // sum_c lags one step behind the completion chain
                if (cnt_reg < n_reg)
                begin
                    rotate     = 1'b1;
                    prev_next  = comp;
                    sum_c_next = sum_c_reg + SW'(prev_reg);
                    sum_a_next = sum_a_reg + SW'(cell_a_reg[0]);
                    sum_b_next = sum_b_reg + SW'(cell_b_reg[0]);
                    cnt_next   = cnt_reg + NW'(1);
                end
                else
                begin
                    state_next = fcfs_sm_pkg::ST_FIN;
                end
            end
            fcfs_sm_pkg::ST_FIN:
            begin
                sum_c_next = sum_c_reg + SW'(prev_reg);
                state_next = fcfs_sm_pkg::ST_TSUM;
            end
            fcfs_sm_pkg::ST_TSUM:
            begin
                // turnaround sum
                sum_c_next = sum_c_reg - sum_a_reg;
                state_next = fcfs_sm_pkg::ST_WSUM;
            end
            fcfs_sm_pkg::ST_WSUM:
            begin
                // waiting sum
                sum_a_next = sum_c_reg - sum_b_reg;
                state_next = fcfs_sm_pkg::ST_DSTART;
            end
            fcfs_sm_pkg::ST_DSTART:
            begin
                div_start  = 1'b1;
                state_next = fcfs_sm_pkg::ST_DIV;
            end
            fcfs_sm_pkg::ST_DIV:
            begin
                if (div_t_done && div_w_done)
                begin
                    avg_t_next = quo_t[19:0];
                    avg_w_next = quo_w[19:0];
                    cnt_next   = '0;
                    prev_next  = '0;
                    state_next = fcfs_sm_pkg::ST_CALC;
                end
            end
            fcfs_sm_pkg::ST_CALC:
            begin
                rotate        = 1'b1;
                prev_next     = comp;
                stg_a_next    = cell_a_reg[0];
                stg_b_next    = cell_b_reg[0];
                stg_i_next    = cell_i_reg[0];
                stg_last_next = (cnt_reg + NW'(1)) == n_reg;
                cnt_next      = cnt_reg + NW'(1);
                state_next    = fcfs_sm_pkg::ST_EMIT;
            end
            fcfs_sm_pkg::ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next                    = 1'b1;
                    out_data_next.process_number      = pnum[4:0];
                    out_data_next.arrival_out         = stg_a_reg;
                    out_data_next.burst_out           = stg_b_reg;
                    out_data_next.completion_time     = prev_reg[20:0];
                    out_data_next.turnaround_time     = tat[19:0];
                    out_data_next.waiting_time        = wt[19:0];
                    out_data_next.average_turnaround  = avg_t_reg;
                    out_data_next.average_waiting     = avg_w_reg;
                    out_data_next.dropped             = ovf_reg;
                    out_data_next.last_result         = stg_last_reg;
                    if (stg_last_reg)
                    begin
                        clear      = 1'b1;
                        n_next     = '0;
                        state_next = fcfs_sm_pkg::ST_LOAD;
                    end
                    else
                    begin
                        state_next = fcfs_sm_pkg::ST_CALC;
                    end
                end
            end
            default:
            begin
                state_next = fcfs_sm_pkg::ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        for (int j = 0; j < MAX_PROCS; j++)
        begin
            cell_a_reg[j] <= cell_a_next[j];
            cell_b_reg[j] <= cell_b_next[j];
            cell_i_reg[j] <= cell_i_next[j];
        end
        prev_reg     <= prev_next;
        sum_c_reg    <= sum_c_next;
        sum_a_reg    <= sum_a_next;
        sum_b_reg    <= sum_b_next;
        avg_t_reg    <= avg_t_next;
        avg_w_reg    <= avg_w_next;
        stg_a_reg    <= stg_a_next;
        stg_b_reg    <= stg_b_next;
        stg_i_reg    <= stg_i_next;
        stg_last_reg <= stg_last_next;
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= fcfs_sm_pkg::ST_LOAD;
            valid_reg     <= '0;
            n_reg         <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            valid_reg     <= valid_next;
            n_reg         <= n_next;
            cnt_reg       <= cnt_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    `FCFS_SM_ASSERT_NOW(a_fill_bound, 1'b1, n_reg <= NW'(MAX_PROCS))
    `FCFS_SM_ASSERT_NOW(a_row_matches_count, 1'b1, $countones(valid_reg) == int'(n_reg))
    `FCFS_SM_ASSERT_NOW(a_run_not_empty, state_reg == fcfs_sm_pkg::ST_SUM, n_reg != '0)
    `FCFS_SM_ASSERT_NOW(a_calc_in_range, state_reg == fcfs_sm_pkg::ST_CALC, cnt_reg < n_reg)
    `FCFS_SM_ASSERT_NEXT(a_div_follows, state_reg == fcfs_sm_pkg::ST_DSTART,
        state_reg == fcfs_sm_pkg::ST_DIV)
endmodule

// ===== hw/rtl/fcfs_schedule_metrics_unit.sv =====
// Top level of the FCFS schedule metrics unit: front, queue and back end.
// Depends on fcfs_sm_pkg, fcfs_sm_chan_if, fcfs_sm_front, fcfs_sm_queue, fcfs_sm_back.
//
//   channel   dir   payload                     transfer when
//   proc      in    fcfs_sm_pkg::proc_item_t    proc.valid && proc.ready
//   result    out   fcfs_sm_pkg::result_item_t  result.valid && result.ready
//
// Loading takes one item per cycle until the two-entry queue fills behind a run.
// A run makes two rotations of the sorted row, one to sum and one to emit, with the
// bit-serial divider in between on a dividend of SW bits, SW being the sum width
// (27 bits at 16 processes).
// Reset (rst_n low, asynchronous) empties the queue, the row and the counters.
// A stalled result holds the back end; the front keeps taking items until the queue is full.
module fcfs_schedule_metrics_unit #(
    parameter int unsigned MAX_PROCS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    fcfs_sm_chan_if.sink   proc,
    fcfs_sm_chan_if.source result
);
    fcfs_sm_pkg::q_stat_t q_stat;
    fcfs_sm_pkg::q_rec_t  q_wr;
    fcfs_sm_pkg::q_rec_t  q_rd;
    logic                 q_push;
    logic                 q_pop;

    // Classify each transfer: count it, or drop it once the set is full.
    fcfs_sm_front #(.MAX_PROCS(MAX_PROCS)) u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .proc   (proc),
        .q_stat (q_stat),
        .push   (q_push),
        .rec    (q_wr)
    );

    // Decouple the front from a busy back end.
    fcfs_sm_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (q_wr),
        .pop     (q_pop),
        .rd_data (q_rd),
        .stat    (q_stat)
    );

    // Sort on insert, run the schedule, divide, emit in run order.
    fcfs_sm_back #(.MAX_PROCS(MAX_PROCS)) u_back (
        .clk    (clk),
        .rst_n  (rst_n),
        .q_stat (q_stat),
        .head   (q_rd),
        .pop    (q_pop),
        .result (result)
    );
endmodule
